// ===== rtl/css_pkg.sv =====
// Package with shared types, constants and control structs for the chord step sequencer.
package css_pkg;

  localparam int MAX_SLOTS       = 16;
  localparam int MAX_CHORD_NOTES = 8;
  localparam int MAX_HELD        = 16;

  localparam logic [6:0]  SEQ_VELOCITY = 7'd100;
  localparam logic [20:0] DEFAULT_LOOP = 21'd4096;

  // Item kinds.
  localparam logic [2:0] KIND_POSITION  = 3'd0;
  localparam logic [2:0] KIND_LOAD_SLOT = 3'd1;
  localparam logic [2:0] KIND_LOAD_NOTE = 3'd2;
  localparam logic [2:0] KIND_TRIGGER   = 3'd3;
  localparam logic [2:0] KIND_RELEASE   = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic               playing;
    logic signed [31:0] position;
    logic [3:0]         slot_index;
    logic [2:0]         note_position;
    logic [15:0]        duration;
    logic [3:0]         note_count;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic               first_of_chord;
    logic [4:0]         channel;
    logic [11:0]        sample_offset;
  } in_word_t;

  typedef struct packed {
    logic        note_on;
    logic [4:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [11:0] out_offset;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SUM, S_DIV_INIT, S_DIV, S_DIV_FIX, S_SEARCH,
    S_COMPARE, S_RELEASE, S_TRIG_ON, S_NOTE_RD, S_NOTE_ON
  } state_t;

  typedef struct packed {
    logic capture;
    logic write_len;
    logic write_note;
    logic set_channel;
    logic clear_current;
    logic set_current;
    logic idx_clear;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic div_fix;
    logic search_step;
    logic rel_emit;
    logic rel_last;
    logic rel_item_offset;
    logic clear_held;
    logic k_clear;
    logic note_read;
    logic note_emit;
    logic trig_emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       playing;
    logic       first_of_chord;
    logic       used_zero;
    logic       held_zero;
    logic       rel_end;
    logic       idx_eq_used;
    logic       search_end;
    logic       search_hit;
    logic       div_done;
    logic       changed;
    logic       cnt_zero;
    logic       k_last;
    logic       emit_ok;
  } status_t;

endpackage

// ===== rtl/chord_step_sequencer_top.sv =====
// Top level of the chord step sequencer: controller joined to datapath.
//
// Input words arrive on cmd_valid/cmd_ready/cmd_word; each one is taken only
// while the block is idle. Note messages leave on msg_valid/msg_ready/msg_word,
// one word per message, with last set on the final message of an input word.
// The user must write the slot_count register through cfg_we/cfg_wdata only
// while idle; the block itself does not enforce this. A load word writes its
// slot table entry, and a trigger or release word sends its messages one after
// another. A position word while playing sums the loop length over the used
// slots, reduces the position modulo it one bit per cycle, searches the slots
// and compares the found slot with the current one, then sends note-offs and
// note-ons; each note-on waits for the registered read of the chord notes.
// A finished message waits in the output register while the next one is
// prepared, so a stalled receiver only pauses emission; nothing is lost.
// Synchronous reset clears the slot count, the chord sizes, the held-note
// list and the current slot, and sets the active channel to one.
module chord_step_sequencer_top
  import css_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  in_word_t   cmd_word,
  output logic       msg_valid,
  input  logic       msg_ready,
  output out_word_t  msg_word
);

  cmd_t    cmd;
  status_t st;

  // Sequencing control.
  css_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  css_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_word  (cmd_word),
    .cmd       (cmd),
    .st        (st),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg_word  (msg_word)
  );

endmodule

// ===== rtl/css_ctrl.sv =====
// Controller state machine that sequences each word through the datapath.
module css_ctrl
  import css_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;
  state_t after_rel, after_rel_next;
  logic   notes_after, notes_after_next;
  logic   item_offset, item_offset_next;

  // State and release bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      after_rel   <= S_IDLE;
      notes_after <= 1'b0;
      item_offset <= 1'b0;
    end else begin
      state       <= state_next;
      after_rel   <= after_rel_next;
      notes_after <= notes_after_next;
      item_offset <= item_offset_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next       = state;
    after_rel_next   = after_rel;
    notes_after_next = notes_after;
    item_offset_next = item_offset;
    cmd              = '0;
    cmd.rel_last        = notes_after ? 1'b0 : st.rel_end;
    cmd.rel_item_offset = item_offset;
    cmd_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (st.kind)
          KIND_POSITION: begin
            cmd.idx_clear = 1'b1;
            if (!st.playing || st.used_zero) begin
              cmd.clear_current = 1'b1;
              after_rel_next    = S_IDLE;
              notes_after_next  = 1'b0;
              item_offset_next  = 1'b0;
              if (!st.held_zero) state_next = S_RELEASE;
            end else begin
              state_next = S_SUM;
            end
          end
          KIND_LOAD_SLOT: cmd.write_len = 1'b1;
          KIND_LOAD_NOTE: cmd.write_note = 1'b1;
          KIND_TRIGGER: begin
            cmd.idx_clear    = 1'b1;
            after_rel_next   = S_TRIG_ON;
            notes_after_next = 1'b1;
            item_offset_next = 1'b1;
            if (st.first_of_chord && !st.held_zero) state_next = S_RELEASE;
            else state_next = S_TRIG_ON;
          end
          KIND_RELEASE: begin
            cmd.idx_clear    = 1'b1;
            cmd.set_channel  = 1'b1;
            after_rel_next   = S_IDLE;
            notes_after_next = 1'b0;
            item_offset_next = 1'b1;
            if (!st.held_zero) state_next = S_RELEASE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SUM: begin
        if (st.idx_eq_used) state_next = S_DIV_INIT;
        else cmd.sum_step = 1'b1;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (st.search_hit || st.search_end) state_next = S_COMPARE;
      end
      S_COMPARE: begin
        state_next = S_IDLE;
        if (st.changed) begin
          cmd.set_current  = 1'b1;
          cmd.k_clear      = 1'b1;
          cmd.idx_clear    = 1'b1;
          after_rel_next   = st.cnt_zero ? S_IDLE : S_NOTE_RD;
          notes_after_next = !st.cnt_zero;
          item_offset_next = 1'b0;
          if (!st.held_zero) state_next = S_RELEASE;
          else if (!st.cnt_zero) state_next = S_NOTE_RD;
        end
      end
      S_RELEASE: begin
        if (st.emit_ok) begin
          cmd.rel_emit = 1'b1;
          if (st.rel_end) begin
            cmd.clear_held = 1'b1;
            state_next     = after_rel;
          end
        end
      end
      S_TRIG_ON: begin
        if (st.emit_ok) begin
          cmd.trig_emit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_NOTE_RD: begin
        cmd.note_read = 1'b1;
        state_next    = S_NOTE_ON;
      end
      S_NOTE_ON: begin
        if (st.emit_ok) begin
          cmd.note_emit = 1'b1;
          state_next    = st.k_last ? S_IDLE : S_NOTE_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/css_dp.sv =====
// Datapath: slot tables, held-note list, loop divider, slot search and message register.
module css_dp
  import css_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata,
  input  in_word_t  cmd_word,
  input  cmd_t      cmd,
  output status_t   st,
  output logic      msg_valid,
  input  logic      msg_ready,
  output out_word_t msg_word
);

  localparam logic [4:0] SLOTS5 = 5'(MAX_SLOTS);
  localparam logic [4:0] HELD5  = 5'(MAX_HELD);
  localparam logic [3:0] CHORD4 = 4'(MAX_CHORD_NOTES);

  in_word_t    item;
  logic [4:0]  slot_count;
  logic [15:0] lens [MAX_SLOTS];
  logic [3:0]  counts [MAX_SLOTS];
  logic [6:0]  notes [MAX_SLOTS*MAX_CHORD_NOTES];
  logic [6:0]  note_rd;
  logic [6:0]  held [MAX_HELD];
  logic [4:0]  held_count;
  logic [4:0]  active_channel;
  logic        current_valid;
  logic [3:0]  current_slot;
  logic [4:0]  idx;
  logic [20:0] total;
  logic [20:0] rem;
  logic [20:0] acc;
  logic [31:0] mag;
  logic [3:0]  found;
  logic [3:0]  k;

  logic [4:0]  used;
  logic [20:0] next_acc;
  logic [21:0] rem_sh;
  logic [20:0] rem_step;
  logic        search_hit;
  logic [3:0]  cnt;
  logic        emit_ok;
  logic        record;
  logic [6:0]  record_note;

  assign used     = (slot_count > SLOTS5) ? SLOTS5 : slot_count;
  assign next_acc = acc + 21'(lens[idx[3:0]]);
  assign search_hit = (rem >= acc) && (rem < next_acc);
  assign rem_sh   = {rem, mag[31]};
  assign rem_step = (rem_sh >= {1'b0, total}) ? 21'(rem_sh - {1'b0, total}) : rem_sh[20:0];
  assign cnt      = counts[found];
  assign emit_ok  = !msg_valid || msg_ready;
  assign record      = cmd.note_emit || cmd.trig_emit;
  assign record_note = cmd.trig_emit ? item.note : note_rd;

  // Status to the controller.
  always_comb begin
    st.kind           = item.kind;
    st.playing        = item.playing;
    st.first_of_chord = item.first_of_chord;
    st.used_zero      = (used == 5'd0);
    st.held_zero      = (held_count == 5'd0);
    st.rel_end        = (idx == held_count - 5'd1);
    st.idx_eq_used    = (idx == used);
    st.search_end     = (idx == used - 5'd1);
    st.search_hit     = search_hit;
    st.div_done       = (idx == 5'd31);
    st.changed        = !current_valid || (found != current_slot);
    st.cnt_zero       = (cnt == 4'd0);
    st.k_last         = (k == cnt - 4'd1);
    st.emit_ok        = emit_ok;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count     <= 5'd0;
      held_count     <= 5'd0;
      active_channel <= 5'd1;
      current_valid  <= 1'b0;
      msg_valid      <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) counts[i] <= 4'd0;
    end else begin
      if (cfg_we) slot_count <= cfg_wdata;
      if (cmd.write_len && ({1'b0, item.slot_index} < SLOTS5))
        counts[item.slot_index] <= (item.note_count > CHORD4) ? CHORD4 : item.note_count;
      if (cmd.set_channel || cmd.trig_emit) active_channel <= item.channel;
      if (cmd.clear_current) current_valid <= 1'b0;
      else if (cmd.set_current) current_valid <= 1'b1;
      if (cmd.clear_held) held_count <= 5'd0;
      else if (record && (held_count < HELD5)) held_count <= held_count + 5'd1;
      if (cmd.rel_emit || record) msg_valid <= 1'b1;
      else if (msg_ready) msg_valid <= 1'b0;
    end
  end

  // Payload registers and tables.
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= cmd_word;
    if (cmd.write_len && ({1'b0, item.slot_index} < SLOTS5)) lens[item.slot_index] <= item.duration;
    if (cmd.set_current) current_slot <= found;
    if (record && (held_count < HELD5)) held[held_count[3:0]] <= record_note;

    // Loop length, divider and slot search share the index counter.
    if (cmd.idx_clear) begin
      idx   <= 5'd0;
      total <= 21'd0;
    end else if (cmd.sum_step) begin
      total <= total + 21'(lens[idx[3:0]]);
      idx   <= idx + 5'd1;
    end else if (cmd.div_init) begin
      if (total == 21'd0) total <= DEFAULT_LOOP;
      rem <= 21'd0;
      mag <= item.position[31] ? 32'(-item.position) : item.position;
      idx <= 5'd0;
    end else if (cmd.div_step) begin
      rem <= rem_step;
      mag <= {mag[30:0], 1'b0};
      idx <= idx + 5'd1;
    end else if (cmd.div_fix) begin
      if (item.position[31] && (rem != 21'd0)) rem <= total - rem;
      acc   <= 21'd0;
      found <= 4'd0;
      idx   <= 5'd0;
    end else if (cmd.search_step) begin
      if (search_hit) found <= idx[3:0];
      acc <= next_acc;
      idx <= idx + 5'd1;
    end else if (cmd.rel_emit) begin
      idx <= idx + 5'd1;
    end

    if (cmd.k_clear) k <= 4'd0;
    else if (cmd.note_emit) k <= k + 4'd1;
  end

  // Chord note memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.write_note && ({1'b0, item.slot_index} < SLOTS5)
        && ({1'b0, item.note_position} < CHORD4))
      notes[{item.slot_index, item.note_position}] <= item.note;
    if (cmd.note_read) note_rd <= notes[{found, k[2:0]}];
  end

  // Outgoing message register.
  always_ff @(posedge clk) begin
    if (cmd.rel_emit) begin
      msg_word.note_on      <= 1'b0;
      msg_word.out_channel  <= active_channel;
      msg_word.out_note     <= held[idx[3:0]];
      msg_word.out_velocity <= 7'd0;
      msg_word.out_offset   <= cmd.rel_item_offset ? item.sample_offset : 12'd0;
      msg_word.last         <= cmd.rel_last;
    end else if (cmd.trig_emit) begin
      msg_word.note_on      <= 1'b1;
      msg_word.out_channel  <= item.channel;
      msg_word.out_note     <= item.note;
      msg_word.out_velocity <= item.velocity;
      msg_word.out_offset   <= item.sample_offset;
      msg_word.last         <= 1'b1;
    end else if (cmd.note_emit) begin
      msg_word.note_on      <= 1'b1;
      msg_word.out_channel  <= active_channel;
      msg_word.out_note     <= note_rd;
      msg_word.out_velocity <= SEQ_VELOCITY;
      msg_word.out_offset   <= 12'd0;
      msg_word.last         <= st.k_last;
    end
  end

endmodule
